[hdl/vweb_pkg.sv]
// ----------------------------------------------------------------------------
// vweb_pkg
// Shared types and constants of the vertex weld and edge builder.
// ----------------------------------------------------------------------------
package vweb_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int MAX_EDGES_DEF    = 1024;
    localparam int COORD_WIDTH_DEF  = 32;

    // Width of one coordinate on the input stream, and of reported indexes.
    localparam int IN_COORD_W = 32;
    localparam int IDX_W      = 10;
    localparam int TAG_W      = 3;

    // Boundary tags of an edge, in priority order.
    localparam logic [TAG_W-1:0] TAG_NONE = 3'd0;
    localparam logic [TAG_W-1:0] TAG_X0   = 3'd1;
    localparam logic [TAG_W-1:0] TAG_X1   = 3'd2;
    localparam logic [TAG_W-1:0] TAG_Y0   = 3'd3;
    localparam logic [TAG_W-1:0] TAG_Y1   = 3'd4;
    localparam logic [TAG_W-1:0] TAG_Z0   = 3'd5;
    localparam logic [TAG_W-1:0] TAG_Z1   = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_lkp_state;

    // Hand-off from the lookup to the edge unit when an item completes.
    typedef struct packed {
        logic fire;      // item completes this cycle
        logic is_break;  // item was a break marker
        logic is_new;    // point was inserted as a new vertex
        logic vfull;     // point matched nothing and the store is full
    } t_commit;

    typedef struct packed {
        logic             vertex_valid;
        logic [IDX_W-1:0] vertex_index;
        logic             vertex_is_new;
        logic             edge_valid;
        logic [IDX_W-1:0] edge_index;
        logic [IDX_W-1:0] edge_from;
        logic [IDX_W-1:0] edge_to;
        logic [TAG_W-1:0] edge_tag;
        logic             store_full;
    } t_result;

endpackage

[hdl/vweb_vertex_mem.sv]
// ----------------------------------------------------------------------------
// vweb_vertex_mem
// Single-port-write, single-port-read vertex memory with registered read data.
// ----------------------------------------------------------------------------
module vweb_vertex_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/vweb_lookup.sv]
// ----------------------------------------------------------------------------
// vweb_lookup
// Finds a point in the vertex memory by linear scan and inserts it if new and the store has room.
// ----------------------------------------------------------------------------
module vweb_lookup #(
    parameter int MAX_V = 1024,
    parameter int CW    = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_is_break,
    input  logic [3*CW-1:0]              i_key,
    input  logic                         i_slot_free,
    output vweb_pkg::t_commit            o_commit,
    output logic [$clog2(MAX_V)-1:0]     o_idx,
    output logic [3*CW-1:0]              o_key
);
    import vweb_pkg::*;

    localparam int AW    = $clog2(MAX_V);
    localparam int CNT_W = $clog2(MAX_V + 1);

    t_lkp_state       r_state, n_state;
    logic [3*CW-1:0]  r_key;
    logic             r_is_break;
    logic [CNT_W-1:0] r_addr;
    logic             r_rd_pend;
    logic [AW-1:0]    r_rd_addr;
    logic             r_hit;
    logic [AW-1:0]    r_idx;
    logic [CNT_W-1:0] r_vcnt;

    logic [3*CW-1:0]  rd_data;
    logic             rd_en;
    logic             wr_en;
    logic             hit_now;
    logic             scan_end;
    logic             accept;
    logic             vfull;
    t_commit          commit;

    vweb_vertex_mem #(
        .DEPTH (MAX_V),
        .WIDTH (3*CW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_vcnt[AW-1:0]),
        .i_wr_data (r_key),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign hit_now  = r_rd_pend && (rd_data == r_key);
    assign scan_end = (r_addr == r_vcnt) && !r_rd_pend;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_is_break ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit_now || scan_end) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == ST_IDLE);
        accept  = o_ready && i_valid;
        rd_en   = (r_state == ST_SCAN) && (r_addr < r_vcnt) && !hit_now;
        vfull   = !r_is_break && !r_hit && (r_vcnt == CNT_W'(MAX_V));
        commit.fire     = (r_state == ST_FINISH) && i_slot_free;
        commit.is_break = r_is_break;
        commit.is_new   = !r_is_break && !r_hit && !vfull;
        commit.vfull    = vfull;
        wr_en = commit.fire && commit.is_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_is_break <= 1'b0;
            r_addr     <= '0;
            r_rd_pend  <= 1'b0;
            r_hit      <= 1'b0;
            r_vcnt     <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_is_break <= i_is_break;
                r_addr     <= '0;
                r_rd_pend  <= 1'b0;
                r_hit      <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_rd_pend <= rd_en;
                if (rd_en) begin
                    r_addr <= r_addr + CNT_W'(1);
                end
                if (hit_now) begin
                    r_hit <= 1'b1;
                end
            end
            if (wr_en) begin
                r_vcnt <= r_vcnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= i_key;
        end
        if (rd_en) begin
            r_rd_addr <= r_addr[AW-1:0];
        end
        if (hit_now) begin
            r_idx <= r_rd_addr;
        end
    end

    assign o_commit = commit;
    assign o_idx    = r_hit ? r_idx : r_vcnt[AW-1:0];
    assign o_key    = r_key;

    a_vcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt <= CNT_W'(MAX_V))
        else $error("vertex count beyond store depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_addr <= r_vcnt))
        else $error("scan address ran past the vertex count");

    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit.fire |=> (r_state == ST_IDLE))
        else $error("lookup did not return to idle after a commit");

endmodule

[hdl/vweb_edge_unit.sv]
// ----------------------------------------------------------------------------
// vweb_edge_unit
// Chain state, edge numbering and boundary tagging; builds the result word.
// ----------------------------------------------------------------------------
module vweb_edge_unit #(
    parameter int MAX_V = 1024,
    parameter int MAX_E = 1024,
    parameter int CW    = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  vweb_pkg::t_commit        i_commit,
    input  logic [$clog2(MAX_V)-1:0] i_idx,
    input  logic [3*CW-1:0]          i_key,
    output vweb_pkg::t_result        o_result
);
    import vweb_pkg::*;

    localparam int AW     = $clog2(MAX_V);
    localparam int ECNT_W = $clog2(MAX_E + 1);
    localparam logic [CW-1:0] ZERO = '0;
    localparam logic [CW-1:0] ONE  = CW'(1) << (CW - 2);

    logic              r_prev_valid;
    logic [AW-1:0]     r_prev_idx;
    logic [3*CW-1:0]   r_prev_key;
    logic [ECNT_W-1:0] r_ecnt;

    logic              pt;
    logic              efull;
    logic              edge_ok;
    logic [TAG_W-1:0]  tag;
    logic [CW-1:0]     px, py, pz, cx, cy, cz;
    t_result           res;

    assign px = r_prev_key[CW-1:0];
    assign py = r_prev_key[2*CW-1:CW];
    assign pz = r_prev_key[3*CW-1:2*CW];
    assign cx = i_key[CW-1:0];
    assign cy = i_key[2*CW-1:CW];
    assign cz = i_key[3*CW-1:2*CW];

    // First face, in tag order, on which both endpoints lie.
    always_comb begin
        if (px == ZERO && cx == ZERO) begin
            tag = TAG_X0;
        end else if (px == ONE && cx == ONE) begin
            tag = TAG_X1;
        end else if (py == ZERO && cy == ZERO) begin
            tag = TAG_Y0;
        end else if (py == ONE && cy == ONE) begin
            tag = TAG_Y1;
        end else if (pz == ZERO && cz == ZERO) begin
            tag = TAG_Z0;
        end else if (pz == ONE && cz == ONE) begin
            tag = TAG_Z1;
        end else begin
            tag = TAG_NONE;
        end
    end

    always_comb begin
        pt      = !i_commit.is_break && !i_commit.vfull;
        efull   = (r_ecnt == ECNT_W'(MAX_E));
        edge_ok = pt && r_prev_valid && !efull;

        res = '0;
        res.vertex_valid  = pt;
        res.vertex_is_new = pt && i_commit.is_new;
        res.store_full    = i_commit.vfull || (pt && r_prev_valid && efull);
        if (pt) begin
            res.vertex_index = IDX_W'(i_idx);
        end
        if (edge_ok) begin
            res.edge_valid = 1'b1;
            res.edge_index = IDX_W'(r_ecnt);
            res.edge_from  = IDX_W'(r_prev_idx);
            res.edge_to    = IDX_W'(i_idx);
            res.edge_tag   = tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
            r_prev_idx   <= '0;
            r_ecnt       <= '0;
        end else if (i_commit.fire) begin
            if (i_commit.is_break) begin
                r_prev_valid <= 1'b0;
            end else if (pt) begin
                r_prev_valid <= 1'b1;
                r_prev_idx   <= i_idx;
            end
            if (edge_ok) begin
                r_ecnt <= r_ecnt + ECNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit.fire && pt) begin
            r_prev_key <= i_key;
        end
    end

    assign o_result = res;

    a_ecnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecnt <= ECNT_W'(MAX_E))
        else $error("edge count beyond its limit");

    a_chain_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit.fire && pt) |=> r_prev_valid)
        else $error("a stored point did not open the chain");

endmodule

[hdl/vertex_weld_edge_builder.sv]
// ----------------------------------------------------------------------------
// vertex_weld_edge_builder
// Welds polyline points into a vertex store and numbers the chain edges.
// ----------------------------------------------------------------------------
// Each input word is a point or a break marker and yields one output word.
// A point is matched against the stored vertices by a linear scan through
// the vertex memory, one entry per cycle over its single read port. A point
// then enters the finish state, and a break marker goes there directly. Each
// item waits in the finish state until the output register is free. The next
// word is taken while the previous result still waits in the output register.
// Stored entries are only read below the vertex count, so the memory needs no
// clearing after reset.
module vertex_weld_edge_builder #(
    parameter int MAX_VERTICES = vweb_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = vweb_pkg::MAX_EDGES_DEF,
    parameter int COORD_WIDTH  = vweb_pkg::COORD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // coord_x[31:0], coord_y[63:32], coord_z[95:64]
    input  logic [95:0] s_axis_tdata,
    // is_break[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // vertex_index[9:0], edge_index[19:10], edge_from[29:20], edge_to[39:30],
    // edge_tag[42:40], zero[47:43]
    output logic [47:0] m_axis_tdata,
    // vertex_valid[0], vertex_is_new[1], edge_valid[2], store_full[3]
    output logic [3:0]  m_axis_tuser
);
    import vweb_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int AW = $clog2(MAX_VERTICES);

    logic [3*CW-1:0] in_key;
    logic [3*CW-1:0] key;
    logic [AW-1:0]   idx;
    logic            slot_free;
    t_commit         commit;
    t_result         res;
    t_result         r_out;
    logic            r_out_valid;

    // Sign-extend each 32-bit coordinate, then keep COORD_WIDTH bits.
    assign in_key = {CW'($signed(s_axis_tdata[3*IN_COORD_W-1:2*IN_COORD_W])),
                     CW'($signed(s_axis_tdata[2*IN_COORD_W-1:IN_COORD_W])),
                     CW'($signed(s_axis_tdata[IN_COORD_W-1:0]))};

    assign slot_free = !r_out_valid || m_axis_tready;

    vweb_lookup #(
        .MAX_V (MAX_VERTICES),
        .CW    (CW)
    ) u_lookup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_is_break  (s_axis_tuser),
        .i_key       (in_key),
        .i_slot_free (slot_free),
        .o_commit    (commit),
        .o_idx       (idx),
        .o_key       (key)
    );

    vweb_edge_unit #(
        .MAX_V (MAX_VERTICES),
        .MAX_E (MAX_EDGES),
        .CW    (CW)
    ) u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (commit),
        .i_idx    (idx),
        .i_key    (key),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit.fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit.fire) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.edge_tag, r_out.edge_to, r_out.edge_from,
                            r_out.edge_index, r_out.vertex_index};
    assign m_axis_tuser  = {r_out.store_full, r_out.edge_valid, r_out.vertex_is_new,
                            r_out.vertex_valid};

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the vertex weld and edge builder.
// ----------------------------------------------------------------------------
// Points and break markers go in on the input stream. A model of the vertex
// store, the chain state and the edge counter inside the bench predicts each
// output word, which is compared field by field in arrival order. A short
// table of directed words covers faces, extremes, repeats and breaks. Random
// traffic follows, then a stretch of mostly fresh points that grows the
// store, then reuse-heavy traffic that ends without any idling.
// Both stream sides stall at random, and the receiver holds off once for a
// long stretch so that the block backs up into its input.
module testbench;

    import vweb_pkg::*;

    localparam int MAX_V        = MAX_VERTICES_DEF;
    localparam int MAX_E        = MAX_EDGES_DEF;
    localparam logic [IN_COORD_W-1:0] UNIT_CODE = 32'h4000_0000;
    localparam logic [IN_COORD_W-1:0] MIN_CODE  = 32'h8000_0000;
    localparam logic [IN_COORD_W-1:0] MAX_CODE  = 32'h7fff_ffff;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = MAX_V + 80;
    localparam int QUIET_LIMIT  = 8000;

    typedef struct packed {
        logic                  brk;
        logic [IN_COORD_W-1:0] x;
        logic [IN_COORD_W-1:0] y;
        logic [IN_COORD_W-1:0] z;
        logic                  typed;
        t_result               want;
    } t_seed_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // coord_x[31:0], coord_y[63:32], coord_z[95:64]
    logic        s_axis_tuser;   // is_break[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // vertex_index[9:0], edge_index[19:10], edge_from[29:20], edge_to[39:30],
    // edge_tag[42:40], zero[47:43]
    logic [47:0] m_axis_tdata;
    // vertex_valid[0], vertex_is_new[1], edge_valid[2], store_full[3]
    logic [3:0]  m_axis_tuser;

    // Shadow of the block's vertex store and chain state.
    logic [IN_COORD_W-1:0] vtx_x [MAX_V];
    logic [IN_COORD_W-1:0] vtx_y [MAX_V];
    logic [IN_COORD_W-1:0] vtx_z [MAX_V];
    int          vtx_count;
    int          edges_made;
    int          prev_idx;
    bit          prev_open;

    t_result     vertex_edge_q[$];
    t_seed_row   seed_rows[$];
    int          fail_count;
    int          results_seen;
    int          quiet_cycles;
    bit          hold_done;
    bit          sender_idles;
    bit          receiver_idles;

    vertex_weld_edge_builder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_result make_word(logic vv, int vi, logic vn, logic ev, int ei,
                                          int ef, int et, logic [TAG_W-1:0] tag,
                                          logic sf);
        t_result w;
        w.vertex_valid  = vv;
        w.vertex_index  = IDX_W'(vi);
        w.vertex_is_new = vn;
        w.edge_valid    = ev;
        w.edge_index    = IDX_W'(ei);
        w.edge_from     = IDX_W'(ef);
        w.edge_to       = IDX_W'(et);
        w.edge_tag      = tag;
        w.store_full    = sf;
        return w;
    endfunction

    // First cube face, in priority order, on which both ends of the edge lie.
    function automatic logic [TAG_W-1:0] face_of(int from, logic [IN_COORD_W-1:0] x,
                                                 logic [IN_COORD_W-1:0] y,
                                                 logic [IN_COORD_W-1:0] z);
        if (vtx_x[from] == '0 && x == '0) return TAG_X0;
        if (vtx_x[from] == UNIT_CODE && x == UNIT_CODE) return TAG_X1;
        if (vtx_y[from] == '0 && y == '0) return TAG_Y0;
        if (vtx_y[from] == UNIT_CODE && y == UNIT_CODE) return TAG_Y1;
        if (vtx_z[from] == '0 && z == '0) return TAG_Z0;
        if (vtx_z[from] == UNIT_CODE && z == UNIT_CODE) return TAG_Z1;
        return TAG_NONE;
    endfunction

    // Finds or inserts the point, closes the chain edge and advances state.
    function automatic t_result weld_and_link(logic brk, logic [IN_COORD_W-1:0] x,
                                              logic [IN_COORD_W-1:0] y,
                                              logic [IN_COORD_W-1:0] z);
        t_result r;
        int      hit;
        bit      found;
        r     = '0;
        hit   = 0;
        found = 1'b0;
        if (brk) begin
            prev_open = 1'b0;
            return r;
        end
        for (int i = 0; i < vtx_count; i++) begin
            if (!found && vtx_x[i] == x && vtx_y[i] == y && vtx_z[i] == z) begin
                hit   = i;
                found = 1'b1;
            end
        end
        if (!found) begin
            // A miss on a full store drops the point and leaves the chain alone.
            if (vtx_count >= MAX_V) begin
                r.store_full = 1'b1;
                return r;
            end
            hit = vtx_count;
            vtx_x[hit] = x;
            vtx_y[hit] = y;
            vtx_z[hit] = z;
            vtx_count++;
            r.vertex_is_new = 1'b1;
        end
        r.vertex_valid = 1'b1;
        r.vertex_index = IDX_W'(hit);
        if (prev_open) begin
            if (edges_made >= MAX_E) begin
                r.store_full = 1'b1;
            end else begin
                r.edge_valid = 1'b1;
                r.edge_index = IDX_W'(edges_made);
                r.edge_from  = IDX_W'(prev_idx);
                r.edge_to    = IDX_W'(hit);
                r.edge_tag   = face_of(prev_idx, x, y, z);
                edges_made++;
            end
        end
        prev_idx  = hit;
        prev_open = 1'b1;
        return r;
    endfunction

    task automatic put_row(logic brk, logic [IN_COORD_W-1:0] x, logic [IN_COORD_W-1:0] y,
                           logic [IN_COORD_W-1:0] z, logic typed, t_result want);
        t_seed_row row;
        row.brk   = brk;
        row.x     = x;
        row.y     = y;
        row.z     = z;
        row.typed = typed;
        row.want  = want;
        seed_rows.push_back(row);
    endtask

    task automatic send_word(logic brk, logic [IN_COORD_W-1:0] x, logic [IN_COORD_W-1:0] y,
                             logic [IN_COORD_W-1:0] z, logic typed, t_result want);
        t_result due;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        s_axis_tuser  <= brk;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        due = weld_and_link(brk, x, y, z);
        vertex_edge_q.push_back(typed ? want : due);
    endtask

    // Coordinates biased toward the cube faces and their near neighbors.
    function automatic logic [IN_COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return UNIT_CODE;
            2: return UNIT_CODE - 1;
            3: return UNIT_CODE + 1;
            4: return -UNIT_CODE;
            5: return MIN_CODE;
            6: return MAX_CODE;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(int brk_pct, int reuse_pct, int reuse_span);
        int                    kind;
        int                    k;
        logic [IN_COORD_W-1:0] x, y, z;
        kind = $urandom_range(0, 99);
        x = $urandom;
        y = $urandom;
        z = $urandom;
        if (kind < brk_pct) begin
            send_word(1'b1, x, y, z, 1'b0, '0);
        end else begin
            if (kind < brk_pct + reuse_pct && vtx_count > 0) begin
                k = $urandom_range(0, (vtx_count < reuse_span ? vtx_count : reuse_span) - 1);
                x = vtx_x[k];
                y = vtx_y[k];
                z = vtx_z[k];
            end else if (kind < brk_pct + reuse_pct + 5 && vtx_count > 0) begin
                x = vtx_x[prev_idx];
                y = vtx_y[prev_idx];
                z = vtx_z[prev_idx];
            end else if (kind < brk_pct + reuse_pct + 35) begin
                x = pick_coord();
                y = pick_coord();
                z = pick_coord();
            end
            send_word(1'b0, x, y, z, 1'b0, '0);
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got.vertex_valid  = m_axis_tuser[0];
            got.vertex_is_new = m_axis_tuser[1];
            got.edge_valid    = m_axis_tuser[2];
            got.store_full    = m_axis_tuser[3];
            got.vertex_index  = m_axis_tdata[9:0];
            got.edge_index    = m_axis_tdata[19:10];
            got.edge_from     = m_axis_tdata[29:20];
            got.edge_to       = m_axis_tdata[39:30];
            got.edge_tag      = m_axis_tdata[42:40];
            if (vertex_edge_q.size() == 0) begin
                $error("output word arrived with no prediction pending");
                fail_count++;
            end else begin
                want = vertex_edge_q.pop_front();
                check_field("vertex_valid", want.vertex_valid, got.vertex_valid);
                check_field("vertex_index", want.vertex_index, got.vertex_index);
                check_field("vertex_is_new", want.vertex_is_new, got.vertex_is_new);
                check_field("edge_valid", want.edge_valid, got.edge_valid);
                check_field("edge_index", want.edge_index, got.edge_index);
                check_field("edge_from", want.edge_from, got.edge_from);
                check_field("edge_to", want.edge_to, got.edge_to);
                check_field("edge_tag", want.edge_tag, got.edge_tag);
                check_field("store_full", want.store_full, got.store_full);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Output side: short random stalls, and one long hold-off early in the run.
    initial begin : result_sink
        m_axis_tready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_done && results_seen >= 60) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (receiver_idles && $urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin : stimulus
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        vtx_count      = 0;
        edges_made     = 0;
        prev_idx       = 0;
        prev_open      = 1'b0;
        fail_count     = 0;
        results_seen   = 0;
        quiet_cycles   = 0;
        hold_done      = 1'b0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;

        put_row(1'b0, 32'h0, 32'h0, 32'h0, 1'b1,
                make_word(1, 0, 1, 0, 0, 0, 0, TAG_NONE, 0));
        put_row(1'b0, UNIT_CODE, 32'h0, 32'h0, 1'b1,
                make_word(1, 1, 1, 1, 0, 0, 1, TAG_Y0, 0));
        put_row(1'b0, UNIT_CODE, UNIT_CODE, 32'h0, 1'b0, '0);
        put_row(1'b0, UNIT_CODE, UNIT_CODE, 32'h0, 1'b0, '0);   // self edge
        put_row(1'b1, 32'h0, 32'h0, 32'h0, 1'b1, '0);
        put_row(1'b1, MAX_CODE, MIN_CODE, 32'hffff_ffff, 1'b1, '0);
        put_row(1'b0, 32'h0, 32'h0, 32'h0, 1'b1,
                make_word(1, 0, 0, 0, 0, 0, 0, TAG_NONE, 0));
        put_row(1'b0, 32'h0, UNIT_CODE, UNIT_CODE, 1'b0, '0);
        put_row(1'b0, UNIT_CODE - 1, UNIT_CODE + 1, -UNIT_CODE, 1'b0, '0);
        put_row(1'b0, MIN_CODE, MIN_CODE, MIN_CODE, 1'b0, '0);
        put_row(1'b0, MAX_CODE, MAX_CODE, MAX_CODE, 1'b0, '0);
        put_row(1'b0, MAX_CODE, MAX_CODE, MIN_CODE, 1'b0, '0);
        put_row(1'b1, 32'h0, 32'h0, 32'h0, 1'b1, '0);
        put_row(1'b0, 32'h123, UNIT_CODE, 32'h77, 1'b0, '0);
        put_row(1'b0, 32'h456, UNIT_CODE, 32'h99, 1'b0, '0);
        put_row(1'b0, 32'h456, 32'h11, 32'h0, 1'b0, '0);
        put_row(1'b0, 32'h789, 32'h22, 32'h0, 1'b0, '0);
        put_row(1'b0, 32'h789, 32'h33, UNIT_CODE, 1'b0, '0);
        put_row(1'b0, 32'haaa, 32'h44, UNIT_CODE, 1'b0, '0);
        put_row(1'b0, 32'h0, 32'h0, 32'h0, 1'b0, '0);
        put_row(1'b0, UNIT_CODE, UNIT_CODE, UNIT_CODE, 1'b0, '0);
        put_row(1'b0, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, '0);
        put_row(1'b0, 32'h0, 32'h0, 32'h1, 1'b0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (seed_rows[i]) begin
            send_word(seed_rows[i].brk, seed_rows[i].x, seed_rows[i].y, seed_rows[i].z,
                      seed_rows[i].typed, seed_rows[i].want);
        end

        // Mixed traffic on a small store, with a stretch of back-to-back words.
        for (int n = 0; n < 200; n++) begin
            sender_idles   = !(n >= 80 && n < 130);
            receiver_idles = sender_idles;
            send_random(10, 25, MAX_V);
        end

        // Mostly fresh points in long chains, so the store and the scans grow.
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        for (int n = 0; n < 180; n++) begin
            send_random(3, 5, 64);
        end

        // Reuse-heavy traffic; the last part runs with no idling at all.
        for (int n = 0; n < 180; n++) begin
            sender_idles   = (n < 100);
            receiver_idles = (n < 100);
            send_random(10, 50, 64);
        end
        s_axis_tvalid <= 1'b0;

        while (vertex_edge_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
